FILE: rtl/core/orm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orm_pkg
// shared types, constants and tables of the oriented rectangle rasterizer
// ----------------------------------------------------------------------------
package orm_pkg;

  localparam int FineBits    = 24;
  localparam int CordicSteps = 16;
  localparam int StepBits    = 4;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam int CornerBits  = 14;

  localparam logic [1:0] RegLength = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegImgW   = 2'd2;
  localparam logic [1:0] RegImgH   = 2'd3;

  localparam logic ActLoad = 1'b0;
  localparam logic ActTest = 1'b1;

  typedef enum logic [2:0] {
    OpIdle, OpCordicInit, OpCordicStep, OpCosSin, OpProducts, OpCorner, OpBox, OpTest
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [1:0]       corner;
    logic [StepBits-1:0] step;
  } dp_cmd_t;

  function automatic logic signed [33:0] atan_fine(input logic [StepBits-1:0] i);
    logic signed [33:0] r;
    case (i)
      4'd0: r = 34'sd2097152;  4'd1: r = 34'sd1238021;
      4'd2: r = 34'sd654136;   4'd3: r = 34'sd332050;
      4'd4: r = 34'sd166669;   4'd5: r = 34'sd83416;
      4'd6: r = 34'sd41718;    4'd7: r = 34'sd20860;
      4'd8: r = 34'sd10430;    4'd9: r = 34'sd5215;
      4'd10: r = 34'sd2608;    4'd11: r = 34'sd1304;
      4'd12: r = 34'sd652;     4'd13: r = 34'sd326;
      4'd14: r = 34'sd163;     default: r = 34'sd81;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/orm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orm_ctrl
// sequencer: cordic iterations, corner writes, box and test steps, handshake
// ----------------------------------------------------------------------------
module orm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                action_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output orm_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StCordic, StCosSin, StProd, StCorner, StBox, StOut
  } state_e;

  state_e state_q;
  logic [orm_pkg::StepBits-1:0] step_q;
  logic [1:0] corner_q;
  logic out_valid_q;

  // idle, or result being taken this cycle
  assign in_ready_o  = (state_q == StIdle) || (state_q == StOut && out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op     = orm_pkg::OpIdle;
    cmd_o.step   = step_q;
    cmd_o.corner = corner_q;
    if (in_ready_o && in_valid_i) begin
      cmd_o.op = (action_i == orm_pkg::ActTest) ? orm_pkg::OpTest : orm_pkg::OpCordicInit;
    end else begin
      unique case (state_q)
        StCordic: cmd_o.op = orm_pkg::OpCordicStep;
        StCosSin: cmd_o.op = orm_pkg::OpCosSin;
        StProd:   cmd_o.op = orm_pkg::OpProducts;
        StCorner: cmd_o.op = orm_pkg::OpCorner;
        StBox:    cmd_o.op = orm_pkg::OpBox;
        default:  cmd_o.op = orm_pkg::OpIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q) inside
        StIdle, StOut: begin
          if (in_ready_o && in_valid_i) begin
            if (action_i == orm_pkg::ActTest) begin
              state_q     <= StOut;
              out_valid_q <= 1'b1;
            end else begin
              state_q     <= StCordic;
              step_q      <= '0;
              out_valid_q <= 1'b0;
            end
          end else if (state_q == StOut && out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= StIdle;
          end
        end
        StCordic: begin
          step_q <= step_q + 1'b1;
          if (step_q == orm_pkg::StepBits'(orm_pkg::CordicSteps - 1)) state_q <= StCosSin;
        end
        StCosSin: state_q <= StProd;
        StProd: begin
          state_q  <= StCorner;
          corner_q <= '0;
        end
        StCorner: begin
          corner_q <= corner_q + 1'b1;
          if (corner_q == 2'd3) state_q <= StBox;
        end
        StBox: begin
          state_q     <= StOut;
          out_valid_q <= 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StOut)
    else $error("result valid outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCordic && step_q == 4'd15) |=> state_q == StCosSin)
    else $error("cordic count broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");

endmodule
`default_nettype wire

FILE: rtl/core/orm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orm_dpath
// cordic, corner rotation, corner store, box clip and edge test
// ----------------------------------------------------------------------------
module orm_dpath #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int ANGLE_BITS      = 16,
  parameter int PIXEL_BITS      = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  orm_pkg::dp_cmd_t       cmd_i,
  input  wire logic [15:0]       center_x_i,
  input  wire logic [15:0]       center_y_i,
  input  wire logic [15:0]       heading_i,
  input  wire logic [PIXEL_BITS-1:0] pixel_x_i,
  input  wire logic [PIXEL_BITS-1:0] pixel_y_i,
  input  wire logic [9:0]        rect_length_i,
  input  wire logic [9:0]        rect_width_i,
  input  wire logic [12:0]       image_width_i,
  input  wire logic [12:0]       image_height_i,
  output logic                   inside_res_o,
  output logic [PIXEL_BITS-1:0]  box_min_x_o,
  output logic [PIXEL_BITS-1:0]  box_max_x_o,
  output logic [PIXEL_BITS-1:0]  box_min_y_o,
  output logic [PIXEL_BITS-1:0]  box_max_y_o,
  output logic                   box_empty_o
);
  localparam int CB = orm_pkg::CornerBits;
  localparam int RS = 16 + COORD_FRAC_BITS;
  localparam int VB = 34 + COORD_FRAC_BITS;

  logic signed [33:0] x_q, y_q, z_q;
  logic [1:0] quad_q;
  logic [15:0] cx_q, cy_q;
  logic signed [16:0] c_q, s_q;
  logic signed [27:0] lc_q, ls_q, wc_q, ws_q;
  logic signed [CB-1:0] col_q [4];
  logic signed [CB-1:0] row_q [4];

  // cordic step
  logic signed [33:0] dx, dy;
  assign dx = y_q >>> cmd_i.step;
  assign dy = x_q >>> cmd_i.step;

  function automatic logic signed [16:0] rnd15(input logic signed [33:0] v);
    logic signed [33:0] a;
    a = v[33] ? -v : v;
    a = (a + 34'sd16384) >>> 15;
    return v[33] ? -17'(a) : 17'(a);
  endfunction

  function automatic logic signed [16:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 17'sd32767;
    if (v < -18'sd32768) return -17'sd32768;
    return 17'(v);
  endfunction

  logic signed [16:0] cq, sq;
  assign cq = rnd15(x_q);
  assign sq = rnd15(y_q);

  // corner value and rounding
  logic sl, sw;
  logic signed [VB-1:0] vx, vy, ax, ay;
  logic signed [VB-1:0] rx, ry;
  logic signed [CB-1:0] kx, ky;
  always_comb begin
    sl = (cmd_i.corner == 2'd1) || (cmd_i.corner == 2'd2);
    sw = cmd_i.corner[1];
    vx = (VB'(cx_q) <<< 16) + (VB'(sl ? lc_q : -lc_q) <<< COORD_FRAC_BITS)
         - (VB'(sw ? ws_q : -ws_q) <<< COORD_FRAC_BITS);
    vy = (VB'(cy_q) <<< 16) + (VB'(sl ? ls_q : -ls_q) <<< COORD_FRAC_BITS)
         + (VB'(sw ? wc_q : -wc_q) <<< COORD_FRAC_BITS);
    ax = vx[VB-1] ? -vx : vx;
    ay = vy[VB-1] ? -vy : vy;
    ax = (ax + (VB'(1) <<< (RS - 1))) >>> RS;
    ay = (ay + (VB'(1) <<< (RS - 1))) >>> RS;
    rx = vx[VB-1] ? -ax : ax;
    ry = vy[VB-1] ? -ay : ay;
    kx = (rx > VB'(8191)) ? CB'(8191) : (rx < -VB'(8192)) ? -CB'(8192) : CB'(rx);
    ky = (ry > VB'(8191)) ? CB'(8191) : (ry < -VB'(8192)) ? -CB'(8192) : CB'(ry);
  end

  // clipped bounding box from stored corners
  logic signed [CB:0] x0, x1, y0, y1, wl, hl;
  logic empty;
  always_comb begin
    x0 = (CB+1)'(col_q[0]); x1 = x0;
    y0 = (CB+1)'(row_q[0]); y1 = y0;
    for (int i = 1; i < 4; i++) begin
      if ((CB+1)'(col_q[i]) < x0) x0 = (CB+1)'(col_q[i]);
      if ((CB+1)'(col_q[i]) > x1) x1 = (CB+1)'(col_q[i]);
      if ((CB+1)'(row_q[i]) < y0) y0 = (CB+1)'(row_q[i]);
      if ((CB+1)'(row_q[i]) > y1) y1 = (CB+1)'(row_q[i]);
    end
    wl = ({2'b0, image_width_i} < (15'd1 << PIXEL_BITS)) ?
         (CB+1)'(image_width_i) : (CB+1)'(15'd1 << PIXEL_BITS);
    hl = ({2'b0, image_height_i} < (15'd1 << PIXEL_BITS)) ?
         (CB+1)'(image_height_i) : (CB+1)'(15'd1 << PIXEL_BITS);
    if (x0 < 0) x0 = '0;
    if (y0 < 0) y0 = '0;
    if (x1 > wl - (CB+1)'(1)) x1 = wl - (CB+1)'(1);
    if (y1 > hl - (CB+1)'(1)) y1 = hl - (CB+1)'(1);
    empty = (x0 > x1) || (y0 > y1);
  end

  // edge cross products, four lanes
  logic signed [CB+1:0] px, py;
  logic cross_ok;
  always_comb begin
    logic signed [CB+1:0] ex, ey, qx, qy;
    logic signed [2*CB+4:0] cp;
    px = (CB+2)'({1'b0, pixel_x_i});
    py = (CB+2)'({1'b0, pixel_y_i});
    cross_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      ex = (CB+2)'(col_q[(i+1)%4]) - (CB+2)'(col_q[i]);
      ey = (CB+2)'(row_q[(i+1)%4]) - (CB+2)'(row_q[i]);
      qx = px - (CB+2)'(col_q[i]);
      qy = py - (CB+2)'(row_q[i]);
      cp = (2*CB+5)'(ex) * (2*CB+5)'(qy) - (2*CB+5)'(ey) * (2*CB+5)'(qx);
      if (cp < 0) cross_ok = 1'b0;
    end
  end

  logic inb;
  assign inb = !empty && px >= (CB+2)'(x0) && px <= (CB+2)'(x1)
               && py >= (CB+2)'(y0) && py <= (CB+2)'(y1);

  logic [ANGLE_BITS-1:0] h;
  assign h = ANGLE_BITS'(heading_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else if (cmd_i.op == orm_pkg::OpCorner) begin
      col_q[cmd_i.corner] <= kx;
      row_q[cmd_i.corner] <= ky;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      orm_pkg::OpCordicInit: begin
        x_q    <= orm_pkg::CordicGain;
        y_q    <= '0;
        z_q    <= 34'($unsigned(h[ANGLE_BITS-3:0])) <<< (orm_pkg::FineBits - ANGLE_BITS);
        quad_q <= h[ANGLE_BITS-1:ANGLE_BITS-2];
        cx_q   <= center_x_i;
        cy_q   <= center_y_i;
      end
      orm_pkg::OpCordicStep: begin
        if (!z_q[33]) begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - orm_pkg::atan_fine(cmd_i.step);
        end else begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + orm_pkg::atan_fine(cmd_i.step);
        end
      end
      orm_pkg::OpCosSin: begin
        case (quad_q)
          2'd0: begin c_q <= sat16(18'(cq));  s_q <= sat16(18'(sq));  end
          2'd1: begin c_q <= sat16(-18'(sq)); s_q <= sat16(18'(cq));  end
          2'd2: begin c_q <= sat16(-18'(cq)); s_q <= sat16(-18'(sq)); end
          default: begin c_q <= sat16(18'(sq)); s_q <= sat16(-18'(cq)); end
        endcase
      end
      orm_pkg::OpProducts: begin
        lc_q <= 28'(c_q) * 28'($signed({1'b0, rect_length_i}));
        ls_q <= 28'(s_q) * 28'($signed({1'b0, rect_length_i}));
        wc_q <= 28'(c_q) * 28'($signed({1'b0, rect_width_i}));
        ws_q <= 28'(s_q) * 28'($signed({1'b0, rect_width_i}));
      end
      orm_pkg::OpBox: begin
        inside_res_o <= 1'b0;
        box_empty_o  <= empty;
        box_min_x_o  <= empty ? '0 : PIXEL_BITS'(x0);
        box_max_x_o  <= empty ? '0 : PIXEL_BITS'(x1);
        box_min_y_o  <= empty ? '0 : PIXEL_BITS'(y0);
        box_max_y_o  <= empty ? '0 : PIXEL_BITS'(y1);
      end
      orm_pkg::OpTest: begin
        inside_res_o <= inb && cross_ok;
        box_empty_o  <= 1'b0;
        box_min_x_o  <= '0;
        box_max_x_o  <= '0;
        box_min_y_o  <= '0;
        box_max_y_o  <= '0;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == orm_pkg::OpTest |=> box_empty_o == 1'b0)
    else $error("test result carries box flag");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == orm_pkg::OpBox |=> !inside_res_o)
    else $error("load result marks inside");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == orm_pkg::OpBox && empty) |=> box_min_x_o == '0 && box_max_y_o == '0)
    else $error("empty box not zeroed");

endmodule
`default_nettype wire

FILE: rtl/core/oriented_rect_mask_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oriented_rect_mask_rasterizer
// rotated rectangle load and per-pixel inside test
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// input     in         in_valid/in_ready  action, center, heading, pixel
// output    out        out_valid/out_ready inside_res, box_*, box_empty
// config    in         apb write/read     rect_length, rect_width, image size
//
// test transaction: result registered on accept, next test taken as the
//   result is taken, so one test per cycle under no stall
// load transaction: accept with cordic init, then 16 cordic iterations,
//   cos/sin, products, four corner writes through one rounding unit, box
// reset clears control state and corners to the origin; output stall holds
// the result and blocks new transactions
// ----------------------------------------------------------------------------
module oriented_rect_mask_rasterizer #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int ANGLE_BITS      = 16,
  parameter int PIXEL_BITS      = 12
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              action_i,
  input  wire logic [15:0]       center_x_i,
  input  wire logic [15:0]       center_y_i,
  input  wire logic [15:0]       heading_i,
  input  wire logic [PIXEL_BITS-1:0] pixel_x_i,
  input  wire logic [PIXEL_BITS-1:0] pixel_y_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   inside_res_o,
  output logic [PIXEL_BITS-1:0]  box_min_x_o,
  output logic [PIXEL_BITS-1:0]  box_max_x_o,
  output logic [PIXEL_BITS-1:0]  box_min_y_o,
  output logic [PIXEL_BITS-1:0]  box_max_y_o,
  output logic                   box_empty_o
);

  logic [9:0]  len_q, wid_q;
  logic [12:0] imw_q, imh_q;
  orm_pkg::dp_cmd_t cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 10'd40;
      wid_q <= 10'd20;
      imw_q <= 13'd640;
      imh_q <= 13'd480;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        orm_pkg::RegLength: len_q <= pwdata[9:0];
        orm_pkg::RegWidth:  wid_q <= pwdata[9:0];
        orm_pkg::RegImgW:   imw_q <= pwdata[12:0];
        orm_pkg::RegImgH:   imh_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      orm_pkg::RegLength: prdata = {22'd0, len_q};
      orm_pkg::RegWidth:  prdata = {22'd0, wid_q};
      orm_pkg::RegImgW:   prdata = {19'd0, imw_q};
      default:            prdata = {19'd0, imh_q};
    endcase
  end

  orm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i,
    .out_valid_o, .out_ready_i, .cmd_o(cmd)
  );

  orm_dpath #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS), .ANGLE_BITS(ANGLE_BITS), .PIXEL_BITS(PIXEL_BITS)
  ) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .center_x_i, .center_y_i, .heading_i,
    .pixel_x_i, .pixel_y_i, .rect_length_i(len_q), .rect_width_i(wid_q),
    .image_width_i(imw_q), .image_height_i(imh_q), .inside_res_o,
    .box_min_x_o, .box_max_x_o, .box_min_y_o, .box_max_y_o, .box_empty_o
  );

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// rectangle pose loads and pixel inside tests, checked against a behavioral
// model of the cordic, corner rounding, box clipping and edge tests
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic        hit;
    logic [11:0] min_x;
    logic [11:0] max_x;
    logic [11:0] min_y;
    logic [11:0] max_y;
    logic        empty;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_ready_o;
  logic action_i = 1'b0;
  logic [15:0] center_x_i = '0, center_y_i = '0, heading_i = '0;
  logic [11:0] pixel_x_i = '0, pixel_y_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic inside_res_o, box_empty_o;
  logic [11:0] box_min_x_o, box_max_x_o, box_min_y_o, box_max_y_o;

  longint len_q = 40, wid_q = 20, img_w_q = 640, img_h_q = 480;
  longint corner_x[4], corner_y[4];
  answer_t answer_q[$];
  int errors = 0;
  int hold_cycles = 0;

  always #4 clk_i = ~clk_i;

  oriented_rect_mask_rasterizer u_dut (.*);

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_half_away(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic heading_cos_sin(input logic [15:0] hd, output longint c, output longint s);
    longint x, y, z, dx, dy, cq, sq;
    x = 652032874;
    y = 0;
    z = longint'(hd[13:0]) << 8;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(orm_pkg::atan_fine(i[3:0]));
      end else begin
        x += dx; y -= dy; z += longint'(orm_pkg::atan_fine(i[3:0]));
      end
    end
    cq = round_half_away(x, 15);
    sq = round_half_away(y, 15);
    case (hd[15:14])
      2'd0: begin c = cq; s = sq; end
      2'd1: begin c = -sq; s = cq; end
      2'd2: begin c = -cq; s = -sq; end
      default: begin c = sq; s = -cq; end
    endcase
    c = clip(c, -32768, 32767);
    s = clip(s, -32768, 32767);
  endtask

  function automatic bit corner_box(output longint x0, output longint x1,
                                    output longint y0, output longint y1);
    longint wl, hl;
    wl = img_w_q < 4096 ? img_w_q : 4096;
    hl = img_h_q < 4096 ? img_h_q : 4096;
    x0 = corner_x[0]; x1 = corner_x[0]; y0 = corner_y[0]; y1 = corner_y[0];
    for (int i = 1; i < 4; i++) begin
      if (corner_x[i] < x0) x0 = corner_x[i];
      if (corner_x[i] > x1) x1 = corner_x[i];
      if (corner_y[i] < y0) y0 = corner_y[i];
      if (corner_y[i] > y1) y1 = corner_y[i];
    end
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > wl - 1) x1 = wl - 1;
    if (y1 > hl - 1) y1 = hl - 1;
    return x0 > x1 || y0 > y1;
  endfunction

  task automatic predict_answer(input logic act, input logic [15:0] cx, input logic [15:0] cy,
                                input logic [15:0] hd, input logic [11:0] px,
                                input logic [11:0] py);
    longint c, s, vx, vy, x0, x1, y0, y1, ex, ey;
    longint sl[4], sw[4];
    bit empty, ins;
    answer_t a;
    sl = '{-1, 1, 1, -1};
    sw = '{-1, -1, 1, 1};
    a = '0;
    if (act == orm_pkg::ActLoad) begin
      heading_cos_sin(hd, c, s);
      for (int i = 0; i < 4; i++) begin
        vx = longint'(cx) * 65536 + (sl[i] * len_q * c - sw[i] * wid_q * s) * 16;
        vy = longint'(cy) * 65536 + (sl[i] * len_q * s + sw[i] * wid_q * c) * 16;
        corner_x[i] = clip(round_half_away(vx, 20), -8192, 8191);
        corner_y[i] = clip(round_half_away(vy, 20), -8192, 8191);
      end
      empty = corner_box(x0, x1, y0, y1);
      a.empty = empty;
      if (!empty) begin
        a.min_x = x0[11:0]; a.max_x = x1[11:0]; a.min_y = y0[11:0]; a.max_y = y1[11:0];
      end
    end else begin
      empty = corner_box(x0, x1, y0, y1);
      ins = !empty && px >= x0 && px <= x1 && py >= y0 && py <= y1;
      for (int i = 0; i < 4; i++) begin
        ex = corner_x[(i + 1) % 4] - corner_x[i];
        ey = corner_y[(i + 1) % 4] - corner_y[i];
        if (ex * (longint'(py) - corner_y[i]) - ey * (longint'(px) - corner_x[i]) < 0)
          ins = 1'b0;
      end
      a.hit = ins;
    end
    answer_q = {answer_q, a};
  endtask

  task automatic send_item(input logic act, input logic [15:0] cx, input logic [15:0] cy,
                           input logic [15:0] hd, input logic [11:0] px,
                           input logic [11:0] py, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act; center_x_i <= cx; center_y_i <= cy; heading_i <= hd;
    pixel_x_i <= px; pixel_y_i <= py;
    do @(posedge clk_i); while (!in_ready_o);
    predict_answer(act, cx, cy, hd, px, py);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      orm_pkg::RegLength: len_q = val & 32'h3ff;
      orm_pkg::RegWidth:  wid_q = val & 32'h3ff;
      orm_pkg::RegImgW:   img_w_q = val & 32'h1fff;
      default:            img_h_q = val & 32'h1fff;
    endcase
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [31:0] l, input logic [31:0] w,
                          input logic [31:0] iw, input logic [31:0] ih);
    drain();
    write_reg(orm_pkg::RegLength, l);
    write_reg(orm_pkg::RegWidth, w);
    write_reg(orm_pkg::RegImgW, iw);
    write_reg(orm_pkg::RegImgH, ih);
  endtask

  // probe mostly near the current box, the rest at random pixels
  task automatic probe_pixels(input int n, input bit no_gap = 0);
    longint x0, x1, y0, y1;
    void'(corner_box(x0, x1, y0, y1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(orm_pkg::ActTest, $urandom, $urandom, $urandom, $urandom, $urandom, no_gap);
      else
        send_item(orm_pkg::ActTest, $urandom, $urandom, $urandom,
                  12'(clip(x0 - 2 + $urandom_range(0, 40 + int'(x1 - x0)), 0, 4095)),
                  12'(clip(y0 - 2 + $urandom_range(0, 40 + int'(y1 - y0)), 0, 4095)), no_gap);
    end
  endtask

  task automatic test_directed();
    send_item(orm_pkg::ActTest, 0, 0, 0, 0, 0);
    send_item(orm_pkg::ActTest, 0, 0, 0, 1, 1);
    send_item(orm_pkg::ActLoad, 16'd320 << 4, 16'd240 << 4, 16'h0000, 0, 0);
    send_item(orm_pkg::ActTest, 0, 0, 0, 320, 240);
    send_item(orm_pkg::ActTest, 0, 0, 0, 300, 230);
    send_item(orm_pkg::ActTest, 0, 0, 0, 299, 240);
    send_item(orm_pkg::ActLoad, 16'd320 << 4, 16'd240 << 4, 16'h2000, 0, 0);
    send_item(orm_pkg::ActTest, 16'hffff, 16'hffff, 16'hffff, 330, 250);
    send_item(orm_pkg::ActLoad, 16'd100 << 4, 16'd100 << 4, 16'h4000, 0, 0);
    send_item(orm_pkg::ActLoad, 16'd100 << 4, 16'd100 << 4, 16'h8000, 0, 0);
    send_item(orm_pkg::ActLoad, 16'd100 << 4, 16'd100 << 4, 16'hc000, 0, 0);
    send_item(orm_pkg::ActLoad, 16'd100 << 4, 16'd100 << 4, 16'hffff, 0, 0);
    send_item(orm_pkg::ActTest, 0, 0, 0, 100, 100);
    send_item(orm_pkg::ActLoad, 16'hffff, 16'hffff, 16'h1234, 0, 0);
    send_item(orm_pkg::ActTest, 0, 0, 0, 12'hfff, 12'hfff);
    send_item(orm_pkg::ActLoad, 0, 0, 16'h4321, 0, 0);
    send_item(orm_pkg::ActTest, 0, 0, 0, 0, 0);
    send_item(orm_pkg::ActLoad, 16'h0008, 16'h0008, 16'h0000, 0, 0);
    send_item(orm_pkg::ActTest, 0, 0, 0, 4095, 0);
  endtask

  task automatic test_register_extremes();
    set_regs(1023, 1023, 4096, 4096);
    send_item(orm_pkg::ActLoad, 16'd2048 << 4, 16'd2048 << 4, 16'h1000, 0, 0);
    probe_pixels(10);
    send_item(orm_pkg::ActLoad, 16'd4000 << 4, 16'd10 << 4, 16'h2000, 0, 0);
    probe_pixels(10);
    set_regs(0, 0, 1, 1);
    send_item(orm_pkg::ActLoad, 0, 0, 16'h0000, 0, 0);
    send_item(orm_pkg::ActTest, 0, 0, 0, 0, 0);
    send_item(orm_pkg::ActLoad, 16'd50 << 4, 16'd50 << 4, 16'h0000, 0, 0);
    set_regs(0, 1023, 0, 0);
    send_item(orm_pkg::ActLoad, 16'd50 << 4, 16'd50 << 4, 16'h3000, 0, 0);
    send_item(orm_pkg::ActTest, 0, 0, 0, 50, 50);
    set_regs(1, 1, 8191, 8191);
    send_item(orm_pkg::ActLoad, 16'h7ff8, 16'h0008, 16'h0000, 0, 0);
    probe_pixels(5);
  endtask

  task automatic test_random(input int n);
    int done;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 9) == 0)
        set_regs($urandom_range(0, 200), $urandom_range(0, 200),
                 $urandom_range(0, 8191), $urandom_range(0, 8191));
      if ($urandom_range(0, 7) == 0) begin
        send_item(orm_pkg::ActLoad, $urandom, $urandom, $urandom, $urandom, $urandom);
        probe_pixels(5);
        done += 6;
      end else begin
        send_item(orm_pkg::ActLoad, 16'($urandom_range(0, 700) << 4 | $urandom_range(0, 15)),
                  16'($urandom_range(0, 500) << 4 | $urandom_range(0, 15)),
                  $urandom, $urandom, $urandom);
        probe_pixels(30);
        done += 31;
      end
    end
  endtask

  task automatic test_output_stall();
    drain();
    set_regs(60, 30, 640, 480);
    send_item(orm_pkg::ActLoad, 16'd200 << 4, 16'd200 << 4, 16'h1800, 0, 0);
    hold_cycles = 200;
    probe_pixels(40, 1);
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    answer_t e;
    if (out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = answer_q.pop_front();
        if (inside_res_o !== e.hit) begin
          $error("inside_res exp %0d got %0d", e.hit, inside_res_o); errors++;
        end
        if (box_min_x_o !== e.min_x) begin
          $error("box_min_x exp %0d got %0d", e.min_x, box_min_x_o); errors++;
        end
        if (box_max_x_o !== e.max_x) begin
          $error("box_max_x exp %0d got %0d", e.max_x, box_max_x_o); errors++;
        end
        if (box_min_y_o !== e.min_y) begin
          $error("box_min_y exp %0d got %0d", e.min_y, box_min_y_o); errors++;
        end
        if (box_max_y_o !== e.max_y) begin
          $error("box_max_y exp %0d got %0d", e.max_y, box_max_y_o); errors++;
        end
        if (box_empty_o !== e.empty) begin
          $error("box_empty exp %0d got %0d", e.empty, box_empty_o); errors++;
        end
      end
    end
  end

  initial begin
    int wait_n;
    wait (rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      wait_n = $urandom_range(0, 2) == 0 ? $urandom_range(0, 15) : 0;
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && hold_cycles == 0);
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_output_stall();
    test_random(1860);
    drain();
    if (errors == 0) $display("** oriented_rect_mask_rasterizer: PASSED **");
    else $display("** oriented_rect_mask_rasterizer: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** oriented_rect_mask_rasterizer: FAILED **");
    $finish;
  end
endmodule
